// ----- hdl/sle_pkg.sv -----
// Shared constants and codes for the serial line editor.
package sle_pkg;

  // Line store geometry and read chunking
  localparam int LINE_DEPTH = 4096;
  localparam int MAX_CHUNK  = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = $clog2(LINE_DEPTH) + 1;
  localparam int CHUNK_W    = $clog2(MAX_CHUNK + 1);
  localparam int CMP_W      = (LEN_W > CHUNK_W) ? LEN_W : CHUNK_W;

  // Field widths
  localparam int CHAR_W     = 8;
  localparam int REQ_W      = 13;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 24;

  // Opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] K_ECHO     = 3'd0;
  localparam logic [KIND_W-1:0] K_DATA     = 3'd1;
  localparam logic [KIND_W-1:0] K_EMPTY    = 3'd2;
  localparam logic [KIND_W-1:0] K_OVERFLOW = 3'd3;
  localparam logic [KIND_W-1:0] K_DROPPED  = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_CTRL_C = 8'd3;
  localparam logic [CHAR_W-1:0] CH_CTRL_D = 8'd4;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL    = 8'd127;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_UP_C   = 8'h43;
  localparam logic [CHAR_W-1:0] CH_UP_D   = 8'h44;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h00;

endpackage

// ----- hdl/serial_line_editor.sv -----
// Top level of the serial line editor: character editing and line reads.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser opcode, tdata char/request length
//  out_    | out | out_tvalid/out_tready| tuser kind, tdata byte, tlast last
//
// One item at a time. A character is accepted, then gives 0 to 3 results.
// A read is accepted, fetches its first byte from the line store, then
// delivers up to 64 bytes, read from the registered line store with the
// next byte prefetched on each take.
// Reset (rst_n low, synchronous) empties the line and clears end of input;
// the line store itself is not cleared. A stalled out_tready holds the current
// result; no new item is accepted until the last result of the current one
// is taken.
module serial_line_editor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sle_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] char_byte, [20:8] request_length
  input  logic                           in_tuser,   // [0] opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sle_pkg::CHAR_W-1:0]     out_tdata,  // [7:0] data_byte
  output logic [sle_pkg::KIND_W-1:0]     out_tuser,  // [2:0] kind
  output logic                           out_tlast   // last
);
  import sle_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_SHOW  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [LEN_W-1:0]   line_len_r, line_len_nxt;
  logic [LEN_W-1:0]   read_pos_r, read_pos_nxt;
  logic               complete_r, complete_nxt;
  logic               eoi_r, eoi_nxt;

  // echo sequence registers
  logic [KIND_W-1:0]  seq_kind_r, seq_kind_nxt;
  logic [CHAR_W-1:0]  seq_b_r [3];
  logic [CHAR_W-1:0]  seq_b_nxt [3];
  logic [1:0]         seq_n_r, seq_n_nxt;
  logic [1:0]         seq_i_r, seq_i_nxt;

  // line walk registers
  logic [LEN_W-1:0]   walk_ptr_r, walk_ptr_nxt;
  logic [CHUNK_W-1:0] walk_cnt_r, walk_cnt_nxt;

  // line store ports
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr;
  logic [CHAR_W-1:0]  st_wdata;
  logic               st_re;
  logic [ADDR_W-1:0]  st_raddr;
  logic [CHAR_W-1:0]  st_rdata;

  logic               in_hs, out_hs;
  logic [CHAR_W-1:0]  ch;
  logic [REQ_W-1:0]   req;
  logic [CHUNK_W-1:0] req_sat;
  logic [LEN_W-1:0]   remaining;
  logic [CMP_W-1:0]   take;
  logic [LEN_W-1:0]   pos_after;
  logic               walk_last;

  assign in_hs  = in_tvalid && in_tready;
  assign out_hs = out_tvalid && out_tready;
  assign ch     = in_tdata[CHAR_W-1:0];
  assign req    = in_tdata[CHAR_W +: REQ_W];

  // read length: saturate, then clip to what is left of the line
  assign req_sat   = (req > REQ_W'(MAX_CHUNK)) ? CHUNK_W'(MAX_CHUNK) : req[CHUNK_W-1:0];
  assign remaining = line_len_r - read_pos_r;
  assign take      = (CMP_W'(req_sat) < CMP_W'(remaining)) ? CMP_W'(req_sat)
                                                             : CMP_W'(remaining);
  assign pos_after = read_pos_r + LEN_W'(take);
  assign walk_last = (walk_cnt_r == CHUNK_W'(1));

  // handshake and result mux
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT) || (state_r == ST_SHOW);
  assign out_tdata  = (state_r == ST_EMIT) ? seq_b_r[seq_i_r] : st_rdata;
  assign out_tuser  = (state_r == ST_EMIT) ? seq_kind_r : K_DATA;
  assign out_tlast  = (state_r == ST_EMIT) ? (seq_i_r == seq_n_r - 2'd1) : walk_last;

  // line store reads: first byte in FETCH, the next one prefetched on each take
  assign st_re    = (state_r == ST_FETCH) || ((state_r == ST_SHOW) && out_hs && !walk_last);
  assign st_raddr = (state_r == ST_FETCH) ? walk_ptr_r[ADDR_W-1:0]
                                          : ADDR_W'(walk_ptr_r + LEN_W'(1));
  assign st_waddr = line_len_r[ADDR_W-1:0];

  // next-state logic
  always_comb begin
    state_nxt    = state_r;
    line_len_nxt = line_len_r;
    read_pos_nxt = read_pos_r;
    complete_nxt = complete_r;
    eoi_nxt      = eoi_r;
    seq_kind_nxt = seq_kind_r;
    seq_b_nxt    = seq_b_r;
    seq_n_nxt    = seq_n_r;
    seq_i_nxt    = seq_i_r;
    walk_ptr_nxt = walk_ptr_r;
    walk_cnt_nxt = walk_cnt_r;
    st_we        = 1'b0;
    st_wdata     = ch;

    unique case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          seq_i_nxt    = 2'd0;
          seq_kind_nxt = K_ECHO;
          seq_b_nxt[0] = CH_ZERO;
          seq_b_nxt[1] = CH_ZERO;
          seq_b_nxt[2] = CH_ZERO;
          if (in_tuser == OP_READ) begin
            if (req == '0 || eoi_r || !complete_r || read_pos_r >= line_len_r) begin
              seq_kind_nxt = K_EMPTY;
              seq_n_nxt    = 2'd1;
              state_nxt    = ST_EMIT;
            end else begin
              walk_ptr_nxt = read_pos_r;
              walk_cnt_nxt = take[CHUNK_W-1:0];
              state_nxt    = ST_FETCH;
              if (pos_after >= line_len_r) begin
                read_pos_nxt = '0;
                line_len_nxt = '0;
                complete_nxt = 1'b0;
              end else begin
                read_pos_nxt = pos_after;
              end
            end
          end else if (complete_r || eoi_r) begin
            // pending line or end of input: drop it
            seq_kind_nxt = K_DROPPED;
            seq_n_nxt    = 2'd1;
            state_nxt    = ST_EMIT;
          end else if (ch == CH_CTRL_D && line_len_r == '0) begin
            seq_b_nxt[0] = CH_CARET;
            seq_b_nxt[1] = CH_UP_D;
            seq_b_nxt[2] = CH_LF;
            seq_n_nxt    = 2'd3;
            eoi_nxt      = 1'b1;
            state_nxt    = ST_EMIT;
          end else if (ch == CH_CTRL_C) begin
            seq_b_nxt[0] = CH_CARET;
            seq_b_nxt[1] = CH_UP_C;
            seq_b_nxt[2] = CH_LF;
            seq_n_nxt    = 2'd3;
            line_len_nxt = '0;
            state_nxt    = ST_EMIT;
          end else if (ch == CH_BS || ch == CH_DEL) begin
            if (line_len_r != '0) begin
              seq_b_nxt[0] = CH_BS;
              seq_b_nxt[1] = CH_SPACE;
              seq_b_nxt[2] = CH_BS;
              seq_n_nxt    = 2'd3;
              line_len_nxt = line_len_r - LEN_W'(1);
              state_nxt    = ST_EMIT;
            end
          end else if (ch == CH_CR || ch == CH_LF) begin
            // end of line; a slot is always kept free for it
            seq_b_nxt[0] = CH_LF;
            seq_n_nxt    = 2'd1;
            st_we        = 1'b1;
            st_wdata     = CH_LF;
            line_len_nxt = line_len_r + LEN_W'(1);
            complete_nxt = 1'b1;
            read_pos_nxt = '0;
            state_nxt    = ST_EMIT;
          end else if (ch < CH_SPACE) begin
            // other control bytes are ignored
          end else if (line_len_r >= LEN_W'(LINE_DEPTH - 1)) begin
            seq_kind_nxt = K_OVERFLOW;
            seq_n_nxt    = 2'd1;
            line_len_nxt = '0;
            state_nxt    = ST_EMIT;
          end else begin
            seq_b_nxt[0] = ch;
            seq_n_nxt    = 2'd1;
            st_we        = 1'b1;
            line_len_nxt = line_len_r + LEN_W'(1);
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_hs) begin
          if (out_tlast) begin
            state_nxt = ST_IDLE;
          end else begin
            seq_i_nxt = seq_i_r + 2'd1;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_hs) begin
          if (walk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            walk_ptr_nxt = walk_ptr_r + LEN_W'(1);
            walk_cnt_nxt = walk_cnt_r - CHUNK_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      line_len_r <= '0;
      read_pos_r <= '0;
      complete_r <= 1'b0;
      eoi_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      line_len_r <= line_len_nxt;
      read_pos_r <= read_pos_nxt;
      complete_r <= complete_nxt;
      eoi_r      <= eoi_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seq_kind_r <= seq_kind_nxt;
    seq_b_r    <= seq_b_nxt;
    seq_n_r    <= seq_n_nxt;
    seq_i_r    <= seq_i_nxt;
    walk_ptr_r <= walk_ptr_nxt;
    walk_cnt_r <= walk_cnt_nxt;
  end

  // line store
  sle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // never take an item while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // line never grows past the store (a full line plus its line feed)
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LEN_W'(LINE_DEPTH))
    else $error("line length beyond store depth");

  // a walk always has bytes left while showing data
  a_walk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHOW) |-> (walk_cnt_r != '0))
    else $error("line walk with no bytes left");

  // the last result frees the input side on the next cycle
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hs && out_tlast) |=> in_tready)
    else $error("input not ready after last result");

endmodule

// ----- hdl/sle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
